// File: design/pcsc_pkg.sv
// Shared definitions for the PNG chunk stream checker: phase codes, order flag
// positions, input and result kinds, error codes, chunk names and the result record.
// No dependencies.
package pcsc_pkg;

	localparam int PHASE_W = 4;

	localparam logic [PHASE_W-1:0] PH_IHDR_LEN  = 4'd0;
	localparam logic [PHASE_W-1:0] PH_IHDR_NAME = 4'd1;
	localparam logic [PHASE_W-1:0] PH_IHDR_BODY = 4'd2;
	localparam logic [PHASE_W-1:0] PH_IHDR_CRC  = 4'd3;
	localparam logic [PHASE_W-1:0] PH_LEN       = 4'd4;
	localparam logic [PHASE_W-1:0] PH_NAME      = 4'd5;
	localparam logic [PHASE_W-1:0] PH_SKIP      = 4'd6;
	localparam logic [PHASE_W-1:0] PH_IDAT      = 4'd7;
	localparam logic [PHASE_W-1:0] PH_CRC       = 4'd8;
	localparam logic [PHASE_W-1:0] PH_IEND_SKIP = 4'd9;
	localparam logic [PHASE_W-1:0] PH_IEND_CRC  = 4'd10;
	localparam logic [PHASE_W-1:0] PH_DONE      = 4'd11;

	localparam int FL_HAVE_IDAT = 0;
	localparam int FL_HAVE_PLTE = 1;
	localparam int FL_PREV_IDAT = 2;
	localparam int FL_INFL_END  = 3;

	localparam logic [1:0] KIND_BYTE     = 2'd0;
	localparam logic [1:0] KIND_END      = 2'd1;
	localparam logic [1:0] KIND_INFL_END = 2'd2;
	localparam logic [1:0] KIND_UNUSED   = 2'd3;

	localparam logic [1:0] RK_PAYLOAD = 2'd0;
	localparam logic [1:0] RK_HEADER  = 2'd1;
	localparam logic [1:0] RK_DONE    = 2'd2;
	localparam logic [1:0] RK_ERROR   = 2'd3;

	localparam logic [3:0] ERR_INPUT_ENDED   = 4'd0;
	localparam logic [3:0] ERR_LENGTH_TOP    = 4'd1;
	localparam logic [3:0] ERR_IHDR_LENGTH   = 4'd2;
	localparam logic [3:0] ERR_NOT_IHDR      = 4'd3;
	localparam logic [3:0] ERR_DEPTH         = 4'd4;
	localparam logic [3:0] ERR_COLOUR        = 4'd5;
	localparam logic [3:0] ERR_COMPRESSION   = 4'd6;
	localparam logic [3:0] ERR_FILTER        = 4'd7;
	localparam logic [3:0] ERR_INTERLACE     = 4'd8;
	localparam logic [3:0] ERR_IDAT_GAP      = 4'd9;
	localparam logic [3:0] ERR_NO_PALETTE    = 4'd10;
	localparam logic [3:0] ERR_IDAT_AFTER    = 4'd11;
	localparam logic [3:0] ERR_PLTE_AFTER    = 4'd12;
	localparam logic [3:0] ERR_UNKNOWN_CRIT  = 4'd13;
	localparam logic [3:0] ERR_NO_IDAT       = 4'd14;
	localparam logic [3:0] ERR_INFLATE_OPEN  = 4'd15;

	localparam logic [31:0] NAME_IHDR = 32'h4948_4452;
	localparam logic [31:0] NAME_IDAT = 32'h4944_4154;
	localparam logic [31:0] NAME_PLTE = 32'h504C_5445;
	localparam logic [31:0] NAME_IEND = 32'h4945_4E44;

	localparam logic [31:0] IHDR_SIZE      = 32'd13;
	localparam int          ANCILLARY_POS  = 29;
	localparam logic [7:0]  INDEXED_COLOUR = 8'd3;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  payload_byte;
		logic [30:0] image_width;
		logic [30:0] image_height;
		logic [4:0]  bit_depth;
		logic [2:0]  color_type;
		logic        interlaced;
		logic [3:0]  error_code;
	} result_t;

endpackage

// File: design/pcsc_in_if.sv
// Input channel of the PNG chunk stream checker: valid/ready handshake with the
// item kind and the file byte. Depends on nothing.
interface pcsc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;

	modport source(output valid, kind, data_byte, input ready);
	modport sink(input valid, kind, data_byte, output ready);
endinterface

// File: design/pcsc_out_if.sv
// Result channel of the PNG chunk stream checker: valid/ready handshake with the
// result fields. Depends on nothing.
interface pcsc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  payload_byte;
	logic [30:0] image_width;
	logic [30:0] image_height;
	logic [4:0]  bit_depth;
	logic [2:0]  color_type;
	logic        interlaced;
	logic [3:0]  error_code;

	modport source(output valid, result_kind, payload_byte, image_width, image_height,
		bit_depth, color_type, interlaced, error_code, input ready);
	modport sink(input valid, result_kind, payload_byte, image_width, image_height,
		bit_depth, color_type, interlaced, error_code, output ready);
endinterface

// File: design/pcsc_core.sv
// Chunk parser state and its combinational step logic: one registered item in,
// at most one result out. Depends on pcsc_pkg.
module pcsc_core import pcsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [1:0] kind,
	input  logic [7:0] data_byte,
	output logic       res_valid,
	output result_t    res
);

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [30:0]        cnt_q, cnt_d;
	logic [30:0]        len_q, len_d;
	logic [31:0]        asm_q, asm_d;
	logic [31:0]        name_q, name_d;
	logic [3:0]         flags_q, flags_d;
	logic [30:0]        hw_q, hw_d;
	logic [30:0]        hh_q, hh_d;
	logic [39:0]        hb_q, hb_d;

	logic [31:0] asm_shift;
	logic [39:0] hb_shift;
	logic [30:0] cnt_inc;
	logic        err_hit;
	logic [3:0]  err_code;
	logic [3:0]  hdr_code;
	logic        hdr_bad;

	function automatic logic [4:0] header_check(input logic [39:0] hb);
		logic [7:0] d;
		logic [7:0] c;
		logic       ok;
		logic [4:0] r;
		d  = hb[39:32];
		c  = hb[31:24];
		ok = 1'b0;
		r  = {1'b0, ERR_INPUT_ENDED};
		case (c)
			8'd0: ok = (d == 8'd1) || (d == 8'd2) || (d == 8'd4) || (d == 8'd8) || (d == 8'd16);
			8'd3: ok = (d == 8'd1) || (d == 8'd2) || (d == 8'd4) || (d == 8'd8);
			8'd2, 8'd4, 8'd6: ok = (d == 8'd8) || (d == 8'd16);
			default: ok = 1'b0;
		endcase
		if (!(c == 8'd0 || c == 8'd2 || c == 8'd3 || c == 8'd4 || c == 8'd6)) begin
			r = {1'b1, ERR_COLOUR};
		end else if (!ok) begin
			r = {1'b1, ERR_DEPTH};
		end else if (hb[23:16] != 8'd0) begin
			r = {1'b1, ERR_COMPRESSION};
		end else if (hb[15:8] != 8'd0) begin
			r = {1'b1, ERR_FILTER};
		end else if (hb[7:0] > 8'd1) begin
			r = {1'b1, ERR_INTERLACE};
		end
		return r;
	endfunction

	assign asm_shift          = {asm_q[23:0], data_byte};
	assign hb_shift           = {hb_q[31:0], data_byte};
	assign cnt_inc            = cnt_q + 31'd1;
	assign {hdr_bad, hdr_code} = header_check(hb_shift);

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		len_d     = len_q;
		asm_d     = asm_q;
		name_d    = name_q;
		flags_d   = flags_q;
		hw_d      = hw_q;
		hh_d      = hh_q;
		hb_d      = hb_q;
		err_hit   = 1'b0;
		err_code  = ERR_INPUT_ENDED;
		res_valid = 1'b0;
		res       = '0;

		if (phase_q == PH_DONE) begin
			phase_d = PH_DONE;
		end else if (kind == KIND_INFL_END) begin
			flags_d[FL_INFL_END] = 1'b1;
		end else if (kind == KIND_UNUSED) begin
			phase_d = phase_q;
		end else if (kind == KIND_END) begin
			err_hit  = 1'b1;
			err_code = ERR_INPUT_ENDED;
		end else begin
			case (phase_q)
				PH_IHDR_LEN, PH_LEN: begin
					asm_d = asm_shift;
					cnt_d = cnt_inc;
					if (cnt_q == 31'd3) begin
						cnt_d = '0;
						if (asm_shift[31]) begin
							err_hit  = 1'b1;
							err_code = ERR_LENGTH_TOP;
						end else if (phase_q == PH_IHDR_LEN && asm_shift != IHDR_SIZE) begin
							err_hit  = 1'b1;
							err_code = ERR_IHDR_LENGTH;
						end else begin
							len_d   = asm_shift[30:0];
							phase_d = (phase_q == PH_IHDR_LEN) ? PH_IHDR_NAME : PH_NAME;
						end
					end
				end
				PH_IHDR_NAME: begin
					asm_d = asm_shift;
					cnt_d = cnt_inc;
					if (cnt_q == 31'd3) begin
						cnt_d  = '0;
						name_d = asm_shift;
						if (asm_shift != NAME_IHDR) begin
							err_hit  = 1'b1;
							err_code = ERR_NOT_IHDR;
						end else begin
							phase_d = PH_IHDR_BODY;
						end
					end
				end
				PH_IHDR_BODY: begin
					cnt_d = cnt_inc;
					if (cnt_q < 31'd8) begin
						asm_d = asm_shift;
						if (cnt_q == 31'd3 || cnt_q == 31'd7) begin
							if (asm_shift[31]) begin
								err_hit  = 1'b1;
								err_code = ERR_LENGTH_TOP;
							end else if (cnt_q == 31'd3) begin
								hw_d = asm_shift[30:0];
							end else begin
								hh_d = asm_shift[30:0];
							end
						end
					end else begin
						hb_d = hb_shift;
						if (cnt_q == 31'd12) begin
							if (hdr_bad) begin
								err_hit  = 1'b1;
								err_code = hdr_code;
							end else begin
								cnt_d   = '0;
								phase_d = PH_IHDR_CRC;
							end
						end
					end
				end
				PH_IHDR_CRC: begin
					cnt_d = cnt_inc;
					if (cnt_q == 31'd3) begin
						cnt_d            = '0;
						phase_d          = PH_LEN;
						res_valid        = 1'b1;
						res.result_kind  = RK_HEADER;
						res.image_width  = hw_q;
						res.image_height = hh_q;
						res.bit_depth    = hb_q[36:32];
						res.color_type   = hb_q[26:24];
						res.interlaced   = hb_q[0];
					end
				end
				PH_NAME: begin
					asm_d = asm_shift;
					cnt_d = cnt_inc;
					if (cnt_q == 31'd3) begin
						name_d = asm_shift;
						if (asm_shift[ANCILLARY_POS]) begin
							flags_d[FL_PREV_IDAT] = 1'b0;
							cnt_d   = '0;
							phase_d = (len_q == '0) ? PH_CRC : PH_SKIP;
						end else if (asm_shift == NAME_IDAT) begin
							if (flags_q[FL_HAVE_IDAT] && !flags_q[FL_PREV_IDAT]) begin
								err_hit  = 1'b1;
								err_code = ERR_IDAT_GAP;
							end else if (hb_q[31:24] == INDEXED_COLOUR && !flags_q[FL_HAVE_PLTE]) begin
								err_hit  = 1'b1;
								err_code = ERR_NO_PALETTE;
							end else if (flags_q[FL_INFL_END]) begin
								err_hit  = 1'b1;
								err_code = ERR_IDAT_AFTER;
							end else begin
								flags_d[FL_HAVE_IDAT] = 1'b1;
								flags_d[FL_PREV_IDAT] = 1'b1;
								cnt_d   = '0;
								phase_d = (len_q == '0) ? PH_CRC : PH_IDAT;
							end
						end else begin
							flags_d[FL_PREV_IDAT] = 1'b0;
							if (asm_shift == NAME_PLTE) begin
								if (flags_q[FL_HAVE_IDAT]) begin
									err_hit  = 1'b1;
									err_code = ERR_PLTE_AFTER;
								end else begin
									flags_d[FL_HAVE_PLTE] = 1'b1;
									cnt_d   = '0;
									phase_d = (len_q == '0) ? PH_CRC : PH_SKIP;
								end
							end else if (asm_shift == NAME_IEND) begin
								cnt_d   = '0;
								phase_d = (len_q == '0) ? PH_IEND_CRC : PH_IEND_SKIP;
							end else begin
								err_hit  = 1'b1;
								err_code = ERR_UNKNOWN_CRIT;
							end
						end
					end
				end
				PH_SKIP, PH_IEND_SKIP: begin
					cnt_d = cnt_inc;
					if (cnt_inc >= len_q) begin
						cnt_d   = '0;
						phase_d = (phase_q == PH_SKIP) ? PH_CRC : PH_IEND_CRC;
					end
				end
				PH_IDAT: begin
					cnt_d = cnt_inc;
					if (cnt_inc >= len_q) begin
						cnt_d   = '0;
						phase_d = PH_CRC;
					end
					res_valid        = 1'b1;
					res.result_kind  = RK_PAYLOAD;
					res.payload_byte = data_byte;
				end
				PH_CRC: begin
					cnt_d = cnt_inc;
					if (cnt_q == 31'd3) begin
						cnt_d   = '0;
						phase_d = PH_LEN;
					end
				end
				PH_IEND_CRC: begin
					cnt_d = cnt_inc;
					if (cnt_q == 31'd3) begin
						cnt_d = '0;
						if (!flags_q[FL_HAVE_IDAT]) begin
							err_hit  = 1'b1;
							err_code = ERR_NO_IDAT;
						end else if (!flags_q[FL_INFL_END]) begin
							err_hit  = 1'b1;
							err_code = ERR_INFLATE_OPEN;
						end else begin
							phase_d         = PH_DONE;
							res_valid       = 1'b1;
							res.result_kind = RK_DONE;
						end
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end

		if (err_hit) begin
			phase_d         = PH_DONE;
			res_valid       = 1'b1;
			res             = '0;
			res.result_kind = RK_ERROR;
			res.error_code  = err_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IHDR_LEN;
			cnt_q   <= '0;
			len_q   <= '0;
			asm_q   <= '0;
			name_q  <= '0;
			flags_q <= '0;
			hw_q    <= '0;
			hh_q    <= '0;
			hb_q    <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			len_q   <= len_d;
			asm_q   <= asm_d;
			name_q  <= name_d;
			flags_q <= flags_d;
			hw_q    <= hw_d;
			hh_q    <= hh_d;
			hb_q    <= hb_d;
		end
	end

	// A finished or failed stream stays that way until reset.
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("checker left the finished phase");

	a_no_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid |-> phase_q != PH_DONE)
		else $error("result produced after the stream finished");

	a_header_from_crc: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid && res.result_kind == RK_HEADER |-> phase_q == PH_IHDR_CRC)
		else $error("header result outside the IHDR CRC phase");

	a_crc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CRC || phase_q == PH_IEND_CRC || phase_q == PH_IHDR_CRC)
		|-> cnt_q < 31'd4)
		else $error("CRC byte counter out of range");

	a_payload_in_idat: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid && res.result_kind == RK_PAYLOAD
		|-> phase_q == PH_IDAT && flags_q[FL_PREV_IDAT])
		else $error("payload forwarded outside an IDAT chunk");

endmodule

// File: design/png_chunk_stream_checker.sv
// PNG chunk stream checker top level: input register, parser core and result register.
// Depends on pcsc_pkg, pcsc_in_if, pcsc_out_if and pcsc_core.
//
// The in channel takes one transaction per file byte (kind 0), starting right after
// the eight-byte signature; kind 1 marks end of input and kind 2 tells the checker
// that the downstream inflater saw the end of the compressed stream.
// The out channel gives at most one transaction per input transaction: a forwarded
// IDAT byte, the decoded IHDR fields once the IHDR CRC bytes are in (never checked), a finished
// indication after IEND, or an error code. After a finish or an error every further
// input is taken and dropped without a result until reset.
// Throughput is one input transaction per clock while the out channel is not stalled.
// An input transaction is held in the input register, then goes through the parser
// step into the result register, which drives the out channel.
// While the receiver stalls a waiting result, one more input transaction is held in
// the input register; in_ch.ready then falls until the result is taken.
// Reset (arst_n low) empties both registers and returns the parser to expecting the
// IHDR length; no clearing pass is needed afterwards.
module png_chunk_stream_checker import pcsc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	pcsc_in_if.sink    in_ch,
	pcsc_out_if.source out_ch
);

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    out_q;
	logic       out_free;
	logic       step_en;
	logic       res_valid;
	result_t    res;

	assign out_free    = !out_valid_q || out_ch.ready;
	assign step_en     = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			kind_s1 <= in_ch.kind;
			byte_s1 <= in_ch.data_byte;
		end
	end

	pcsc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.kind      (kind_s1),
		.data_byte (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= res_valid;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res_valid) begin
			out_q <= res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.result_kind  = out_q.result_kind;
	assign out_ch.payload_byte = out_q.payload_byte;
	assign out_ch.image_width  = out_q.image_width;
	assign out_ch.image_height = out_q.image_height;
	assign out_ch.bit_depth    = out_q.bit_depth;
	assign out_ch.color_type   = out_q.color_type;
	assign out_ch.interlaced   = out_q.interlaced;
	assign out_ch.error_code   = out_q.error_code;

endmodule

// File: tb/png_chunk_stream_checker_tb.sv
// Self-checking testbench for png_chunk_stream_checker: it builds a PNG chunk stream
// with random content and one planned ending, and predicts every result transaction.
// Depends on pcsc_pkg, pcsc_in_if, pcsc_out_if and the png_chunk_stream_checker RTL.
import pcsc_pkg::*;

class chunk_stream_scoreboard;
	logic [3:0]  phase;
	logic [31:0] field_cnt;
	logic [30:0] chunk_len;
	logic [31:0] word_acc;
	logic [31:0] chunk_name;
	logic [3:0]  flags;
	logic [30:0] hdr_width;
	logic [30:0] hdr_height;
	logic [39:0] hdr_bytes;
	result_t     expected_results[$];
	int          mismatches;
	int          results_checked;
	int          payload_results;

	function new();
		phase = PH_IHDR_LEN;
		field_cnt = '0;
		chunk_len = '0;
		word_acc = '0;
		chunk_name = '0;
		flags = '0;
		hdr_width = '0;
		hdr_height = '0;
		hdr_bytes = '0;
		mismatches = 0;
		results_checked = 0;
		payload_results = 0;
	endfunction

	function logic [7:0] header_byte(int pos);
		return hdr_bytes[8*(4-pos) +: 8];
	endfunction

	function void push_result(logic [1:0] rk, logic [7:0] pb, logic [30:0] w, logic [30:0] h,
			logic [4:0] d, logic [2:0] c, logic il, logic [3:0] ec);
		result_t r;
		r.result_kind = rk;
		r.payload_byte = pb;
		r.image_width = w;
		r.image_height = h;
		r.bit_depth = d;
		r.color_type = c;
		r.interlaced = il;
		r.error_code = ec;
		expected_results.push_back(r);
	endfunction

	function void stop_with(logic [3:0] code);
		phase = PH_DONE;
		push_result(RK_ERROR, '0, '0, '0, '0, '0, 1'b0, code);
	endfunction

	// Returns the fault flag in bit 4 and the error code below it.
	function logic [4:0] header_verdict();
		logic [7:0] depth;
		logic [7:0] colour;
		bit         pow2;
		bit         ok;
		depth = header_byte(0);
		colour = header_byte(1);
		pow2 = (depth == 8'd1 || depth == 8'd2 || depth == 8'd4 || depth == 8'd8 || depth == 8'd16);
		case (colour)
			8'd0: ok = pow2;
			INDEXED_COLOUR: ok = pow2 && depth != 8'd16;
			8'd2, 8'd4, 8'd6: ok = (depth == 8'd8 || depth == 8'd16);
			default: return {1'b1, ERR_COLOUR};
		endcase
		if (!ok) return {1'b1, ERR_DEPTH};
		if (header_byte(2) != 8'd0) return {1'b1, ERR_COMPRESSION};
		if (header_byte(3) != 8'd0) return {1'b1, ERR_FILTER};
		if (header_byte(4) > 8'd1) return {1'b1, ERR_INTERLACE};
		return 5'd0;
	endfunction

	function void open_body(logic [3:0] body_phase, logic [3:0] crc_phase);
		field_cnt = '0;
		phase = (chunk_len == '0) ? crc_phase : body_phase;
	endfunction

	function void note_input(logic [1:0] kind, logic [7:0] b);
		int         idx;
		logic [4:0] verdict;
		logic [7:0] d;
		logic [7:0] c;
		logic [7:0] il;
		if (phase == PH_DONE) return;
		if (kind == KIND_INFL_END) begin
			flags[FL_INFL_END] = 1'b1;
			return;
		end
		if (kind == KIND_UNUSED) return;
		if (kind == KIND_END) begin
			stop_with(ERR_INPUT_ENDED);
			return;
		end
		case (phase)
			PH_IHDR_LEN, PH_LEN: begin
				word_acc = {word_acc[23:0], b};
				field_cnt++;
				if (field_cnt < 4) return;
				field_cnt = '0;
				if (word_acc[31]) begin
					stop_with(ERR_LENGTH_TOP);
					return;
				end
				if (phase == PH_IHDR_LEN && word_acc != IHDR_SIZE) begin
					stop_with(ERR_IHDR_LENGTH);
					return;
				end
				chunk_len = word_acc[30:0];
				phase = (phase == PH_IHDR_LEN) ? PH_IHDR_NAME : PH_NAME;
			end
			PH_IHDR_NAME: begin
				word_acc = {word_acc[23:0], b};
				field_cnt++;
				if (field_cnt < 4) return;
				field_cnt = '0;
				chunk_name = word_acc;
				if (chunk_name != NAME_IHDR) stop_with(ERR_NOT_IHDR);
				else phase = PH_IHDR_BODY;
			end
			PH_IHDR_BODY: begin
				idx = int'(field_cnt);
				field_cnt++;
				if (idx < 8) begin
					word_acc = {word_acc[23:0], b};
					if (idx == 3 || idx == 7) begin
						if (word_acc[31]) stop_with(ERR_LENGTH_TOP);
						else if (idx == 3) hdr_width = word_acc[30:0];
						else hdr_height = word_acc[30:0];
					end
					return;
				end
				hdr_bytes = {hdr_bytes[31:0], b};
				if (idx < 12) return;
				verdict = header_verdict();
				if (verdict[4]) begin
					stop_with(verdict[3:0]);
				end else begin
					field_cnt = '0;
					phase = PH_IHDR_CRC;
				end
			end
			PH_IHDR_CRC: begin
				field_cnt++;
				if (field_cnt < 4) return;
				field_cnt = '0;
				phase = PH_LEN;
				d = header_byte(0);
				c = header_byte(1);
				il = header_byte(4);
				push_result(RK_HEADER, '0, hdr_width, hdr_height, d[4:0], c[2:0], il[0], 4'd0);
			end
			PH_NAME: begin
				word_acc = {word_acc[23:0], b};
				field_cnt++;
				if (field_cnt < 4) return;
				chunk_name = word_acc;
				if (chunk_name[ANCILLARY_POS]) begin
					flags[FL_PREV_IDAT] = 1'b0;
					open_body(PH_SKIP, PH_CRC);
				end else if (chunk_name == NAME_IDAT) begin
					if (flags[FL_HAVE_IDAT] && !flags[FL_PREV_IDAT]) begin
						stop_with(ERR_IDAT_GAP);
					end else if (header_byte(1) == INDEXED_COLOUR && !flags[FL_HAVE_PLTE]) begin
						stop_with(ERR_NO_PALETTE);
					end else if (flags[FL_INFL_END]) begin
						stop_with(ERR_IDAT_AFTER);
					end else begin
						flags[FL_HAVE_IDAT] = 1'b1;
						flags[FL_PREV_IDAT] = 1'b1;
						open_body(PH_IDAT, PH_CRC);
					end
				end else begin
					flags[FL_PREV_IDAT] = 1'b0;
					if (chunk_name == NAME_PLTE) begin
						if (flags[FL_HAVE_IDAT]) begin
							stop_with(ERR_PLTE_AFTER);
						end else begin
							flags[FL_HAVE_PLTE] = 1'b1;
							open_body(PH_SKIP, PH_CRC);
						end
					end else if (chunk_name == NAME_IEND) begin
						open_body(PH_IEND_SKIP, PH_IEND_CRC);
					end else begin
						stop_with(ERR_UNKNOWN_CRIT);
					end
				end
			end
			PH_SKIP, PH_IEND_SKIP: begin
				field_cnt++;
				if (field_cnt >= {1'b0, chunk_len}) begin
					field_cnt = '0;
					phase = (phase == PH_SKIP) ? PH_CRC : PH_IEND_CRC;
				end
			end
			PH_IDAT: begin
				field_cnt++;
				if (field_cnt >= {1'b0, chunk_len}) begin
					field_cnt = '0;
					phase = PH_CRC;
				end
				push_result(RK_PAYLOAD, b, '0, '0, '0, '0, 1'b0, 4'd0);
			end
			PH_CRC: begin
				field_cnt++;
				if (field_cnt < 4) return;
				field_cnt = '0;
				phase = PH_LEN;
			end
			PH_IEND_CRC: begin
				field_cnt++;
				if (field_cnt < 4) return;
				field_cnt = '0;
				if (!flags[FL_HAVE_IDAT]) begin
					stop_with(ERR_NO_IDAT);
				end else if (!flags[FL_INFL_END]) begin
					stop_with(ERR_INFLATE_OPEN);
				end else begin
					phase = PH_DONE;
					push_result(RK_DONE, '0, '0, '0, '0, '0, 1'b0, 4'd0);
				end
			end
			default: phase = PH_DONE;
		endcase
	endfunction

	task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("Mismatch at %0t on result %0d: %s is 0x%0h, expected 0x%0h",
				$time, results_checked, what, got, want);
	endtask

	task check_result(result_t got);
		result_t want;
		results_checked++;
		if (got.result_kind == RK_PAYLOAD) payload_results++;
		if (expected_results.size() == 0) begin
			report_mismatch("result_kind with nothing expected", 32'(got.result_kind), '0);
			return;
		end
		want = expected_results.pop_front();
		if (got.result_kind !== want.result_kind)
			report_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
		if (got.payload_byte !== want.payload_byte)
			report_mismatch("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
		if (got.image_width !== want.image_width)
			report_mismatch("image_width", 32'(got.image_width), 32'(want.image_width));
		if (got.image_height !== want.image_height)
			report_mismatch("image_height", 32'(got.image_height), 32'(want.image_height));
		if (got.bit_depth !== want.bit_depth)
			report_mismatch("bit_depth", 32'(got.bit_depth), 32'(want.bit_depth));
		if (got.color_type !== want.color_type)
			report_mismatch("color_type", 32'(got.color_type), 32'(want.color_type));
		if (got.interlaced !== want.interlaced)
			report_mismatch("interlaced", 32'(got.interlaced), 32'(want.interlaced));
		if (got.error_code !== want.error_code)
			report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
	endtask
endclass

module png_chunk_stream_checker_tb;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int BODY_TARGET = 1450;
	localparam logic [7:0] CT_GREY = 8'd0;
	localparam logic [7:0] CT_RGB = 8'd2;
	localparam logic [7:0] CT_GREY_ALPHA = 8'd4;
	localparam logic [7:0] CT_RGBA = 8'd6;

	typedef enum {END_CLEAN, END_INPUT_CUT, END_LENGTH_TOP, END_IDAT_GAP, END_IDAT_AFTER_INFLATE,
		END_PLTE_LATE, END_UNKNOWN_CRITICAL, END_INFLATE_OPEN, END_NO_PALETTE, END_NO_IDAT,
		END_BAD_HEADER} stream_ending_t;
	typedef enum {FLAW_LENGTH, FLAW_LENGTH_TOP, FLAW_NAME, FLAW_WIDTH_TOP, FLAW_HEIGHT_TOP,
		FLAW_COLOUR, FLAW_DEPTH, FLAW_COMPRESSION, FLAW_FILTER, FLAW_INTERLACE} header_flaw_t;

	logic clk;
	logic arst_n;
	pcsc_in_if  in_ch();
	pcsc_out_if out_ch();

	png_chunk_stream_checker dut(
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	chunk_stream_scoreboard sb;
	stream_ending_t ending;
	logic [7:0] header_colour;
	int stream_items;
	int filler_items;
	int quiet_cycles;
	bit steady_input;
	bit steady_output;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int idle_length(bit steady);
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic int small_length();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r == 9) return $urandom_range(25, 64);
		return $urandom_range(1, 24);
	endfunction

	function automatic logic [31:0] ancillary_name();
		logic [31:0] n;
		n = $urandom;
		n[ANCILLARY_POS] = 1'b1;
		return n;
	endfunction

	function automatic logic [31:0] critical_name();
		logic [31:0] n;
		do begin
			n = $urandom;
			n[ANCILLARY_POS] = 1'b0;
		end while (n == NAME_IHDR || n == NAME_IDAT || n == NAME_PLTE || n == NAME_IEND);
		return n;
	endfunction

	function automatic logic [31:0] dimension();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) return 32'd0;
		if (r == 1) return 32'h7FFF_FFFF;
		return $urandom & 32'h7FFF_FFFF;
	endfunction

	function automatic logic [7:0] legal_depth(logic [7:0] colour);
		if (colour == CT_GREY) return 8'd1 << $urandom_range(0, 4);
		if (colour == INDEXED_COLOUR) return 8'd1 << $urandom_range(0, 3);
		return 8'd8 << $urandom_range(0, 1);
	endfunction

	task automatic send_item(logic [1:0] kind, logic [7:0] value);
		int gap;
		gap = idle_length(steady_input);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.data_byte <= value;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
	endtask

	task automatic send_byte(logic [7:0] value);
		if ($urandom_range(0, 31) == 0) begin
			send_item(KIND_UNUSED, 8'($urandom));
			filler_items++;
		end
		if ($urandom_range(0, 199) == 0) steady_input = !steady_input;
		send_item(KIND_BYTE, value);
		stream_items++;
	endtask

	task automatic send_signal(logic [1:0] kind);
		send_item(kind, 8'($urandom));
		stream_items++;
	endtask

	task automatic send_word(logic [31:0] w);
		for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
	endtask

	task automatic send_chunk(logic [31:0] name, logic [31:0] len);
		send_word(len);
		send_word(name);
		repeat (len) send_byte(8'($urandom));
		repeat (4) send_byte(8'($urandom));
	endtask

	task automatic send_header();
		logic [31:0]  len;
		logic [31:0]  name;
		logic [31:0]  w;
		logic [31:0]  h;
		logic [7:0]   depth;
		logic [7:0]   comp;
		logic [7:0]   filt;
		logic [7:0]   lace;
		logic [7:0]   colours [5];
		header_flaw_t flaw;
		colours = '{CT_GREY, CT_RGB, INDEXED_COLOUR, CT_GREY_ALPHA, CT_RGBA};
		header_colour = colours[$urandom_range(0, 4)];
		if (ending == END_NO_PALETTE) header_colour = INDEXED_COLOUR;
		depth = legal_depth(header_colour);
		w = dimension();
		h = dimension();
		len = IHDR_SIZE;
		name = NAME_IHDR;
		comp = 8'd0;
		filt = 8'd0;
		lace = 8'($urandom_range(0, 1));
		if (ending == END_BAD_HEADER) begin
			flaw = header_flaw_t'($urandom_range(0, 9));
			case (flaw)
				FLAW_LENGTH: len = $urandom_range(0, 12);
				FLAW_LENGTH_TOP: len = $urandom | 32'h8000_0000;
				FLAW_NAME: name = NAME_IHDR ^ (32'd1 << $urandom_range(0, 31));
				FLAW_WIDTH_TOP: w[31] = 1'b1;
				FLAW_HEIGHT_TOP: h[31] = 1'b1;
				FLAW_COLOUR: begin
					if ($urandom_range(0, 1)) header_colour = $urandom_range(0, 1) ? 8'd1 : 8'd5;
					else header_colour = 8'($urandom_range(7, 255));
				end
				FLAW_DEPTH: begin
					if ($urandom_range(0, 1)) depth = 8'd0;
					else depth = (header_colour == INDEXED_COLOUR) ? 8'd16 : 8'd7;
				end
				FLAW_COMPRESSION: comp = 8'($urandom_range(1, 255));
				FLAW_FILTER: filt = 8'($urandom_range(1, 255));
				default: lace = 8'($urandom_range(2, 255));
			endcase
		end
		send_word(len);
		send_word(name);
		send_word(w);
		send_word(h);
		send_byte(depth);
		send_byte(header_colour);
		send_byte(comp);
		send_byte(filt);
		send_byte(lace);
		repeat (4) send_byte(8'($urandom));
	endtask

	task automatic send_ending();
		case (ending)
			END_INPUT_CUT: begin
				repeat ($urandom_range(0, 6)) send_byte(8'($urandom));
				send_signal(KIND_END);
			end
			END_LENGTH_TOP: send_word($urandom | 32'h8000_0000);
			END_IDAT_GAP: begin
				send_chunk(ancillary_name(), small_length());
				send_chunk(NAME_IDAT, small_length());
			end
			END_IDAT_AFTER_INFLATE: begin
				send_signal(KIND_INFL_END);
				send_chunk(NAME_IDAT, small_length());
			end
			END_PLTE_LATE: send_chunk(NAME_PLTE, 3 * $urandom_range(1, 4));
			END_UNKNOWN_CRITICAL: send_chunk(critical_name(), small_length());
			default: begin
				repeat ($urandom_range(0, 2)) send_chunk(ancillary_name(), small_length());
				if (ending != END_INFLATE_OPEN) send_signal(KIND_INFL_END);
				send_chunk(NAME_IEND, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
			end
		endcase
	endtask

	initial begin
		sb = new();
		stream_items = 0;
		filler_items = 0;
		steady_input = 1'b0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.kind <= KIND_BYTE;
		in_ch.data_byte <= 8'd0;
		ending = ($urandom_range(0, 99) < 30) ? END_CLEAN : stream_ending_t'($urandom_range(1, 10));
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_header();
		send_chunk(ancillary_name(), 0);
		if (ending != END_NO_PALETTE && (header_colour == INDEXED_COLOUR || $urandom_range(0, 1)))
			repeat ($urandom_range(1, 2)) send_chunk(NAME_PLTE, 3 * $urandom_range(0, 4));
		send_chunk(ancillary_name(), small_length());
		if (ending == END_NO_IDAT) begin
			while (stream_items < BODY_TARGET)
				send_chunk(($urandom_range(0, 3) == 0) ? NAME_PLTE : ancillary_name(),
					small_length());
		end else begin
			send_chunk(NAME_IDAT, 0);
			send_chunk(NAME_IDAT, 1);
			while (stream_items < BODY_TARGET) send_chunk(NAME_IDAT, small_length());
		end
		send_ending();

		// Once the stream has finished or failed, everything further must be dropped silently.
		repeat (20) begin
			send_item(2'($urandom_range(0, 3)), 8'($urandom));
			filler_items++;
		end
		in_ch.valid <= 1'b0;

		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d stream transactions and %0d filler ones, planned ending %s.",
			stream_items, filler_items, ending.name());
		$display("Compared %0d results, %0d of them forwarded IDAT bytes, with %0d mismatches.",
			sb.results_checked, sb.payload_results, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		int hold;
		steady_output = 1'b0;
		out_ch.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			hold = idle_length(steady_output);
			if (hold > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			if ($urandom_range(0, 49) == 0) steady_output = !steady_output;
		end
	end

	always @(posedge clk) begin : monitor
		result_t got;
		bit      moved;
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			moved = 1'b0;
			if (in_ch.valid && in_ch.ready) begin
				sb.note_input(in_ch.kind, in_ch.data_byte);
				moved = 1'b1;
			end
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.result_kind, out_ch.payload_byte, out_ch.image_width,
					out_ch.image_height, out_ch.bit_depth, out_ch.color_type,
					out_ch.interlaced, out_ch.error_code};
				sb.check_result(got);
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles, %0d results still expected.",
					WATCHDOG_LIMIT, sb.expected_results.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end
endmodule

// File: sim.f
design/pcsc_pkg.sv
design/pcsc_in_if.sv
design/pcsc_out_if.sv
design/pcsc_core.sv
design/png_chunk_stream_checker.sv
tb/png_chunk_stream_checker_tb.sv
